/* hw/rtl/plu_pkg.sv */
// ----------------------------------------------------------------------------
// plu_pkg
// Types, constants and helpers for the particle leapfrog update pipeline.
// ----------------------------------------------------------------------------
package plu_pkg;

	localparam int StGrav     = 1;
	localparam int StSquare   = 2;
	localparam int StSum      = 3;
	localparam int StSqrtLast = 35;
	localparam int StLimNum   = 36;
	localparam int StDivFirst = 37;
	localparam int StDivLast  = 67;
	localparam int StLimApply = 68;
	localparam int StMul      = 69;
	localparam int StVel      = 70;
	localparam int StPosMul   = 71;
	localparam int StPosAdd   = 72;
	localparam int StPdvFirst = 73;
	localparam int StPdvLast  = 105;
	localparam int NumStages  = 106;

	localparam logic [30:0] TimeStepRst   = 31'd655;
	localparam logic [30:0] SimScaleRst   = 31'd65536;
	localparam logic [31:0] GravityRst    = 32'hFFF6_3333;
	localparam logic [30:0] ForceLimitRst = 31'd39321600;
	localparam logic [30:0] XsphFactorRst = 31'd6554;

	typedef enum logic [2:0] {
		REG_TIME_STEP   = 3'd0,
		REG_SIM_SCALE   = 3'd1,
		REG_GRAVITY     = 3'd2,
		REG_FORCE_LIMIT = 3'd3,
		REG_XSPH_FACTOR = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [2:0][31:0] p;
		logic [2:0][31:0] v;
		logic [2:0][31:0] c;
		logic [2:0][31:0] f;
		logic [2:0][63:0] pa;
		logic [2:0][63:0] pb;
		logic [63:0]      m2;
		logic             lim;
		logic [35:0]      sr;
		logic [31:0]      sq;
		logic [2:0][62:0] fl;
		logic [2:0][32:0] dr;
		logic [2:0][30:0] dq;
		logic [2:0][31:0] vn;
		logic [2:0][31:0] hv;
		logic [2:0][31:0] r2;
		logic [2:0][32:0] q2;
		logic [2:0]       clamp;
		logic [2:0][31:0] pn;
	} stage_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] x);
		logic [31:0] r;
		if (x > 64'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (x < -64'sd2147483648)
			r = 32'h8000_0000;
		else
			r = x[31:0];
		return r;
	endfunction

	function automatic logic [31:0] abs32(input logic [31:0] x);
		return x[31] ? (32'd0 - x) : x;
	endfunction

	function automatic logic signed [63:0] sext64(input logic [31:0] x);
		return $signed({{32{x[31]}}, x});
	endfunction

endpackage

/* hw/rtl/particle_leapfrog_update_unit.sv */
// ----------------------------------------------------------------------------
// particle_leapfrog_update_unit
// Leapfrog step for one SPH particle per word, with force limiting and XSPH.
//
// Input channel (in_valid/in_stall) takes one particle per word: position,
// velocity, force and XSPH correction, each three Q16.16 components.
// Output channel (out_valid/out_stall) gives new position, new velocity and
// half-step velocity. One result word per input word, in order.
// Throughput is one word per cycle unless out_stall holds the output word.
// Depth is set by the bit-serial square root (32 stages) and the two restoring
// dividers (31 and 33 stages), one result bit per stage.
// When the output word is held by out_stall the whole pipeline freezes and
// in_stall is raised in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults. Registers
// are written through the APB port and must only change while idle.
// ----------------------------------------------------------------------------
module particle_leapfrog_update_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic signed [31:0] force_x,
	input  logic signed [31:0] force_y,
	input  logic signed [31:0] force_z,
	input  logic signed [31:0] corr_x,
	input  logic signed [31:0] corr_y,
	input  logic signed [31:0] corr_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_pos_z,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic signed [31:0] new_vel_z,
	output logic signed [31:0] half_vel_x,
	output logic signed [31:0] half_vel_y,
	output logic signed [31:0] half_vel_z
);
	import plu_pkg::*;

	logic [30:0] time_step_q;
	logic [30:0] sim_scale_q;
	logic [31:0] gravity_q;
	logic [30:0] force_limit_q;
	logic [30:0] xsph_factor_q;
	logic [63:0] lim_sq_q;
	logic [30:0] scale_q;

	logic   adv;
	stage_t in_word;
	stage_t src [0:NumStages-1];
	stage_t nxt [1:NumStages];
	stage_t pipe_s [1:NumStages];
	logic   vld_s [1:NumStages];

	// register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q   <= TimeStepRst;
			sim_scale_q   <= SimScaleRst;
			gravity_q     <= GravityRst;
			force_limit_q <= ForceLimitRst;
			xsph_factor_q <= XsphFactorRst;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_TIME_STEP:   time_step_q   <= pwdata[30:0];
				REG_SIM_SCALE:   sim_scale_q   <= pwdata[30:0];
				REG_GRAVITY:     gravity_q     <= pwdata;
				REG_FORCE_LIMIT: force_limit_q <= pwdata[30:0];
				REG_XSPH_FACTOR: xsph_factor_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_TIME_STEP:   prdata = {1'b0, time_step_q};
			REG_SIM_SCALE:   prdata = {1'b0, sim_scale_q};
			REG_GRAVITY:     prdata = gravity_q;
			REG_FORCE_LIMIT: prdata = {1'b0, force_limit_q};
			REG_XSPH_FACTOR: prdata = {1'b0, xsph_factor_q};
			default:         prdata = '0;
		endcase
	end

	// derived settings, registered from the control registers
	always_ff @(posedge clk) begin
		lim_sq_q <= 64'(force_limit_q) * 64'(force_limit_q);
		scale_q  <= (sim_scale_q == '0) ? 31'd1 : sim_scale_q;
	end

	// pipeline
	assign adv      = !(vld_s[NumStages] && out_stall);
	assign in_stall = !adv;

	always_comb begin
		in_word   = '0;
		in_word.p = {pos_z, pos_y, pos_x};
		in_word.v = {vel_z, vel_y, vel_x};
		in_word.f = {force_z, force_y, force_x};
		in_word.c = {corr_z, corr_y, corr_x};
	end

	assign src[0] = in_word;

	for (genvar k = 1; k <= NumStages; k++) begin : g_st
		localparam int SqBit = (k > StSum && k <= StSqrtLast) ? 2 * (StSqrtLast - k) : 0;
		localparam int DvBit = (k >= StDivFirst && k <= StDivLast) ? StDivLast - k : 0;
		localparam int PdBit = (k >= StPdvFirst && k <= StPdvLast) ? StPdvLast - k : 0;

		if (k < NumStages) begin : g_src
			assign src[k] = pipe_s[k];
		end

		always_comb begin
			stage_t            pv;
			stage_t            n;
			logic signed [32:0] gs;
			logic [31:0]        m;
			logic [35:0]        r;
			logic [35:0]        t;
			logic [32:0]        rp;
			logic [32:0]        rd;
			logic [31:0]        rq;
			logic [31:0]        rq2;
			logic signed [63:0] a;
			logic signed [63:0] b;
			logic signed [63:0] s;
			logic [63:0]        num;
			logic [32:0]        d;
			pv  = src[k-1];
			n   = pv;
			gs  = '0;
			m   = '0;
			r   = '0;
			t   = '0;
			rp  = '0;
			rd  = '0;
			rq  = '0;
			rq2 = '0;
			a   = '0;
			b   = '0;
			s   = '0;
			num = '0;
			d   = '0;
			if (k == StGrav) begin
				gs = $signed({pv.f[2][31], pv.f[2]}) + $signed({gravity_q[31], gravity_q});
				n.f[2] = sat32($signed({{31{gs[32]}}, gs}));
			end else if (k == StSquare) begin
				for (int i = 0; i < 3; i++) begin
					m = abs32(pv.f[i]);
					n.pa[i] = 64'(m) * 64'(m);
				end
			end else if (k == StSum) begin
				n.m2  = pv.pa[0] + pv.pa[1] + pv.pa[2];
				n.lim = n.m2 > lim_sq_q;
				n.sr  = '0;
				n.sq  = '0;
			end else if (k <= StSqrtLast) begin
				// one root bit per stage
				r = {pv.sr[33:0], pv.m2[SqBit +: 2]};
				t = {2'b00, pv.sq, 2'b01};
				if (r >= t) begin
					n.sr = r - t;
					n.sq = {pv.sq[30:0], 1'b1};
				end else begin
					n.sr = r;
					n.sq = {pv.sq[30:0], 1'b0};
				end
			end else if (k == StLimNum) begin
				for (int i = 0; i < 3; i++)
					n.fl[i] = 63'(64'(abs32(pv.f[i])) * 64'(force_limit_q));
			end else if (k <= StDivLast) begin
				for (int i = 0; i < 3; i++) begin
					rp = (k == StDivFirst) ? {2'b00, pv.fl[i][61:31]} : pv.dr[i];
					rd = {rp[31:0], pv.fl[i][DvBit]};
					if (rd >= {1'b0, pv.sq}) begin
						n.dr[i] = rd - {1'b0, pv.sq};
						n.dq[i][DvBit] = 1'b1;
					end else begin
						n.dr[i] = rd;
						n.dq[i][DvBit] = 1'b0;
					end
				end
			end else if (k == StLimApply) begin
				for (int i = 0; i < 3; i++) begin
					if (pv.lim) begin
						if (pv.sq == '0)
							n.f[i] = '0;
						else if (pv.f[i][31])
							n.f[i] = 32'd0 - {1'b0, pv.dq[i]};
						else
							n.f[i] = {1'b0, pv.dq[i]};
					end
				end
			end else if (k == StMul) begin
				for (int i = 0; i < 3; i++) begin
					n.pa[i] = $signed({33'd0, time_step_q}) * sext64(pv.f[i]);
					n.pb[i] = $signed({33'd0, xsph_factor_q}) * sext64(pv.c[i]);
				end
			end else if (k == StVel) begin
				for (int i = 0; i < 3; i++) begin
					a = ($signed(pv.pa[i]) + 64'sd32768) >>> 16;
					b = ($signed(pv.pb[i]) + 64'sd32768) >>> 16;
					s = sext64(pv.v[i]) + a + b;
					n.vn[i] = sat32(s);
					s = (sext64(pv.v[i]) + sext64(n.vn[i])) >>> 1;
					n.hv[i] = s[31:0];
				end
			end else if (k == StPosMul) begin
				for (int i = 0; i < 3; i++)
					n.fl[i] = 63'(64'(abs32(pv.vn[i])) * 64'(time_step_q));
			end else if (k == StPosAdd) begin
				for (int i = 0; i < 3; i++) begin
					num        = 64'(pv.fl[i]) + 64'(scale_q[30:1]);
					n.fl[i]    = num[62:0];
					n.clamp[i] = num >= {scale_q, 33'd0};
				end
			end else if (k <= StPdvLast) begin
				for (int i = 0; i < 3; i++) begin
					rq  = (k == StPdvFirst) ? {2'b00, pv.fl[i][62:33]} : pv.r2[i];
					rq2 = {rq[30:0], pv.fl[i][PdBit]};
					if (rq2 >= {1'b0, scale_q}) begin
						n.r2[i] = rq2 - {1'b0, scale_q};
						n.q2[i][PdBit] = 1'b1;
					end else begin
						n.r2[i] = rq2;
						n.q2[i][PdBit] = 1'b0;
					end
				end
			end else begin
				for (int i = 0; i < 3; i++) begin
					d = pv.clamp[i] ? '1 : pv.q2[i];
					if (pv.vn[i][31])
						s = sext64(pv.p[i]) - $signed({31'd0, d});
					else
						s = sext64(pv.p[i]) + $signed({31'd0, d});
					n.pn[i] = sat32(s);
				end
			end
			nxt[k] = n;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (adv)
				vld_s[k] <= (k == 1) ? in_valid : vld_s[k-1 + (k == 1 ? 1 : 0)];
		end

		always_ff @(posedge clk) begin
			if (adv)
				pipe_s[k] <= nxt[k];
		end
	end

	assign out_valid  = vld_s[NumStages];
	assign new_pos_x  = pipe_s[NumStages].pn[0];
	assign new_pos_y  = pipe_s[NumStages].pn[1];
	assign new_pos_z  = pipe_s[NumStages].pn[2];
	assign new_vel_x  = pipe_s[NumStages].vn[0];
	assign new_vel_y  = pipe_s[NumStages].vn[1];
	assign new_vel_z  = pipe_s[NumStages].vn[2];
	assign half_vel_x = pipe_s[NumStages].hv[0];
	assign half_vel_y = pipe_s[NumStages].hv[1];
	assign half_vel_z = pipe_s[NumStages].hv[2];

	a_speed_ge_limit: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[StSqrtLast] && pipe_s[StSqrtLast].lim
		|-> pipe_s[StSqrtLast].sq >= {1'b0, force_limit_q})
		else $error("root below force limit");

	a_limited_force: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[StLimApply] && pipe_s[StLimApply].lim
		|-> abs32(pipe_s[StLimApply].f[0]) <= {1'b0, force_limit_q})
		else $error("limited force above limit");

	a_pos_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[StPosAdd] && !pipe_s[StPosAdd].clamp[0]
		|-> pipe_s[StPosAdd].fl[0][62:33] < scale_q)
		else $error("position quotient overflows");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for particle_leapfrog_update_unit. Particle words are
// fed with random gaps, results are drained under random and long stalls,
// and every result is compared against an in-bench leapfrog calculation
// over several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb;
	import plu_pkg::*;

	typedef bit [11:0][31:0] particle_t;   // pos, vel, force, corr (x,y,z each)
	typedef bit [8:0][31:0]  update_t;     // new pos, new vel, half vel

	class leapfrog_board;
		longint dt, scl, grav, flim, xw;
		update_t pending[$];
		int errors;
		string names[9] = '{"new_pos_x", "new_pos_y", "new_pos_z", "new_vel_x",
			"new_vel_y", "new_vel_z", "half_vel_x", "half_vel_y", "half_vel_z"};

		function new();
			dt = TimeStepRst; scl = SimScaleRst; grav = $signed(GravityRst);
			flim = ForceLimitRst; xw = XsphFactorRst; errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, bit [31:0] val);
			case (idx)
				REG_TIME_STEP:   dt = val[30:0];
				REG_SIM_SCALE:   scl = val[30:0];
				REG_GRAVITY:     grav = $signed(val);
				REG_FORCE_LIMIT: flim = val[30:0];
				REG_XSPH_FACTOR: xw = val[30:0];
				default: ;
			endcase
		endfunction

		static function longint clamp32(longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		static function longint unsigned mag(longint x);
			return x < 0 ? longint'(0) - x : x;
		endfunction

		static function longint unsigned root(longint unsigned n);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function void note_input(particle_t w);
			longint p[3], v[3], f[3], c[3], a, b, vn, s;
			longint unsigned m2, speed, sc, num, d, q;
			update_t r;
			for (int i = 0; i < 3; i++) begin
				p[i] = $signed(w[i]); v[i] = $signed(w[3+i]);
				f[i] = $signed(w[6+i]); c[i] = $signed(w[9+i]);
			end
			f[2] = clamp32(f[2] + grav);
			m2 = 0;
			for (int i = 0; i < 3; i++) m2 += mag(f[i]) * mag(f[i]);
			if (m2 > longint'(flim * flim)) begin
				speed = root(m2);
				for (int i = 0; i < 3; i++) begin
					q = speed == 0 ? 0 : mag(f[i]) * longint'(flim) / speed;
					f[i] = f[i] < 0 ? -longint'(q) : longint'(q);
				end
			end
			sc = scl == 0 ? 1 : scl;
			for (int i = 0; i < 3; i++) begin
				a = (dt * f[i] + 32768) >>> 16;
				b = (xw * c[i] + 32768) >>> 16;
				vn = clamp32(v[i] + a + b);
				num = longint'(dt) * mag(vn);
				d = (num + sc / 2) / sc;
				r[i] = clamp32(vn < 0 ? p[i] - longint'(d) : p[i] + longint'(d));
				r[3+i] = vn;
				s = v[i] + vn;
				r[6+i] = s >>> 1;
			end
			pending.push_back(r);
		endfunction

		function void check_result(update_t got);
			update_t want;
			if (pending.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
				return;
			end
			want = pending.pop_front();
			for (int i = 0; i < 9; i++)
				if (got[i] !== want[i]) begin
					$error("%s: expected %h, got %h", names[i], want[i], got[i]);
					errors++;
				end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        psel, penable, pwrite, pready;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        in_valid, in_stall, out_valid, out_stall;
	logic [31:0] din [12];
	logic signed [31:0] dout [9];

	leapfrog_board board = new();
	bit src_idle = 1, sink_idle = 1, hold_req = 0;
	int quiet = 0;

	particle_leapfrog_update_unit uut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall,
		.pos_x(din[0]), .pos_y(din[1]), .pos_z(din[2]),
		.vel_x(din[3]), .vel_y(din[4]), .vel_z(din[5]),
		.force_x(din[6]), .force_y(din[7]), .force_z(din[8]),
		.corr_x(din[9]), .corr_y(din[10]), .corr_z(din[11]),
		.out_valid, .out_stall,
		.new_pos_x(dout[0]), .new_pos_y(dout[1]), .new_pos_z(dout[2]),
		.new_vel_x(dout[3]), .new_vel_y(dout[4]), .new_vel_z(dout[5]),
		.half_vel_x(dout[6]), .half_vel_y(dout[7]), .half_vel_z(dout[8])
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic reg_write(reg_idx_t idx, bit [31:0] val);
		@(negedge clk);
		psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
		board.set_reg(idx, val);
	endtask

	task automatic set_all(bit [31:0] t, bit [31:0] sc, bit [31:0] g, bit [31:0] fl,
			bit [31:0] xs);
		reg_write(REG_TIME_STEP, t);
		reg_write(REG_SIM_SCALE, sc);
		reg_write(REG_GRAVITY, g);
		reg_write(REG_FORCE_LIMIT, fl);
		reg_write(REG_XSPH_FACTOR, xs);
	endtask

	// called and returns at a falling edge
	task automatic send(particle_t w);
		if (src_idle && $urandom_range(0, 5) == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		for (int i = 0; i < 12; i++) din[i] = w[i];
		in_valid = 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_input(w);
		@(negedge clk);
	endtask

	// called at a falling edge, right after the last send
	task automatic drain();
		in_valid = 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (130) @(posedge clk);
	endtask

	function automatic bit [31:0] pick();
		bit [31:0] x;
		case ($urandom_range(0, 7))
			0, 1: x = $urandom;
			2: begin
				case ($urandom_range(0, 4))
					0: x = 32'h7FFF_FFFF;
					1: x = 32'h8000_0000;
					2: x = 32'hFFFF_FFFF;
					3: x = 32'h0000_0001;
					default: x = 32'h0;
				endcase
			end
			default: begin
				x = $urandom >> $urandom_range(8, 24);
				if ($urandom_range(0, 1)) x = -x;
			end
		endcase
		return x;
	endfunction

	function automatic particle_t rand_particle();
		particle_t w;
		for (int i = 0; i < 12; i++) w[i] = pick();
		return w;
	endfunction

	function automatic particle_t directed(int k);
		particle_t w;
		w = '0;
		case (k)
			0: ;
			1: w = {12{32'h7FFF_FFFF}};
			2: w = {12{32'h8000_0000}};
			3: w = {12{32'hFFFF_FFFF}};
			4: w = {12{32'hAAAA_AAAA}};
			5: w = {12{32'h5555_5555}};
			6: w[8] = 32'd39321600 + 32'd642253;         // force exactly at the limit
			7: w[8] = 32'd39321600 + 32'd642254;         // just over it
			8: begin w[3] = 32'h7FFF_FFF0; w[6] = 32'h7FFF_FFFF; end
			9: begin w[3] = 32'h8000_0010; w[6] = 32'h8000_0000; end
			10: begin w[0] = 32'h7FFF_FFFF; w[3] = 32'h7FFF_FFFF; end
			11: begin w[0] = 32'h8000_0000; w[3] = 32'h8000_0000; end
			12: begin w[3] = 32'hFFFF_FFFF; w[4] = 32'd1; w[5] = 32'd3; end
			13: begin w[6] = 32'd50; w[9] = 32'hFFFF_FFF6; w[10] = 32'd5; end
			14: begin w[8] = 32'h0009_CCCD; w[11] = 32'h7FFF_FFFF; end
			default: w = rand_particle();
		endcase
		return w;
	endfunction

	// sink: stall bursts and one long hold-off
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_stall = 1;
				repeat (300) @(negedge clk);
				out_stall = 0;
			end else if (sink_idle && $urandom_range(0, 5) == 0) begin
				out_stall = 1;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				out_stall = 0;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			board.check_result({dout[8], dout[7], dout[6], dout[5], dout[4],
				dout[3], dout[2], dout[1], dout[0]});

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= 4000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_valid = 0;
		for (int i = 0; i < 12; i++) din[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		for (int k = 0; k < 15; k++) send(directed(k));
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_all(655, 65536, 32'hFFF6_3333, 39321600, 6554);
				1: set_all(32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
				2: set_all(0, 0, 32'h8000_0000, 0, 0);
				3: set_all(65536, 32'h7FFF_FFFF, 0, 65536, 65536);
				7: set_all(655, 65536, 32'hFFF6_3333, 39321600, 6554);
				default: set_all($urandom_range(0, 32'h0002_0000),
					$urandom_range(1, 32'h7FFF_FFFF), $urandom,
					$urandom_range(0, 32'h7FFF_FFFF), $urandom_range(0, 32'h0004_0000));
			endcase
			if (ph == 2)
				for (int k = 0; k < 8; k++) send(directed(k));
			if (ph == 4) hold_req = 1;
			if (ph == 7) begin
				src_idle = 0;
				sink_idle = 0;
			end
			for (int n = 0; n < 100; n++) send(rand_particle());
			drain();
		end

		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

/* filelist.f */
hw/rtl/plu_pkg.sv
hw/rtl/particle_leapfrog_update_unit.sv
dv/tb.sv
